@@ rtl/core/ewa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewa_pkg
// Shared constants, controller states, datapath operations and status bundle
// for the earliest-free worker assigner.
// ----------------------------------------------------------------------------
package ewa_pkg;

   // Default heap capacity
   localparam int MAX_WORKERS_DEFAULT = 1024;

   // Field widths
   localparam int DUR_W   = 32;
   localparam int TIME_W  = 48;
   localparam int IDX_W   = 10;
   localparam int CFG_W   = 11;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // Reset value of the worker count register
   localparam int WORKERS_RESET = 4;

   // Register index of workers_in_use (taken from paddr[2])
   localparam logic CSR_IDX_WORKERS = 1'b0;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CHILD,
      ST_ITEM,
      ST_FINAL
   } state_type;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLR_INIT,
      OP_CLR_STEP,
      OP_LOAD,
      OP_PICK,
      OP_PLACE,
      OP_FINISH
   } op_type;

   // Datapath status to the controller
   typedef struct packed {
      logic clr_last;
      logic has_child;
      logic swap;
   } status_type;

endpackage

@@ rtl/core/ewa_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewa_csr
// APB-style register port holding the worker count; flags each count write so
// the heap can be rebuilt.
// ----------------------------------------------------------------------------
module ewa_csr #(
   parameter int MAX_WORKERS = ewa_pkg::MAX_WORKERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ewa_pkg::ADDR_W-1:0]    paddr,
   input  logic [ewa_pkg::DATA_W-1:0]    pwdata,
   output logic [ewa_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output logic                          cfg_wr,
   output logic [$clog2(MAX_WORKERS+1)-1:0] workers
);

   localparam int CW = $clog2(MAX_WORKERS + 1);
   localparam int RESET_COUNT = (ewa_pkg::WORKERS_RESET > MAX_WORKERS) ?
                                MAX_WORKERS : ewa_pkg::WORKERS_RESET;

   logic [CW-1:0]               workers_ff;
   logic [CW-1:0]               workers_in;
   logic [ewa_pkg::CFG_W-1:0]   wr_value;
   logic                        sel_workers;

   assign sel_workers = (paddr[2] == ewa_pkg::CSR_IDX_WORKERS);
   assign cfg_wr      = psel && penable && pwrite && sel_workers;
   assign wr_value    = pwdata[ewa_pkg::CFG_W-1:0];

   // Clamp the written count into 1 .. MAX_WORKERS
   always_comb begin
      if (wr_value == '0) begin
         workers_in = CW'(1);
      end else if (32'(wr_value) > 32'(MAX_WORKERS)) begin
         workers_in = CW'(MAX_WORKERS);
      end else begin
         workers_in = CW'(wr_value);
      end
   end

   // Hold the count, load on a write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         workers_ff <= CW'(RESET_COUNT);
      end else if (cfg_wr) begin
         workers_ff <= workers_in;
      end
   end

   // Read back
   assign prdata  = sel_workers ? ewa_pkg::DATA_W'(workers_ff) : '0;
   assign pready  = 1'b1;
   assign workers = workers_ff;

endmodule

@@ rtl/core/ewa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewa_ctrl
// Controller for the clearing pass and the per-job sift-down sequence.
// ----------------------------------------------------------------------------
module ewa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                cfg_wr,
   input  ewa_pkg::status_type status,
   output ewa_pkg::op_type     op,
   output logic                busy
);

   ewa_pkg::state_type state_ff;
   ewa_pkg::state_type state_in;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ewa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      if (cfg_wr) begin
         state_in = ewa_pkg::ST_CLEAR;
      end else begin
         case (state_ff)
            ewa_pkg::ST_IDLE: begin
               if (start) begin
                  state_in = status.has_child ? ewa_pkg::ST_CHILD : ewa_pkg::ST_FINAL;
               end
            end
            ewa_pkg::ST_CLEAR: begin
               if (status.clr_last) begin
                  state_in = ewa_pkg::ST_IDLE;
               end
            end
            ewa_pkg::ST_CHILD: begin
               state_in = ewa_pkg::ST_ITEM;
            end
            ewa_pkg::ST_ITEM: begin
               if (!status.swap) begin
                  state_in = ewa_pkg::ST_IDLE;
               end else if (status.has_child) begin
                  state_in = ewa_pkg::ST_CHILD;
               end else begin
                  state_in = ewa_pkg::ST_FINAL;
               end
            end
            ewa_pkg::ST_FINAL: begin
               state_in = ewa_pkg::ST_IDLE;
            end
            default: begin
               state_in = ewa_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // Drive datapath operation
   always_comb begin
      op = ewa_pkg::OP_NONE;
      if (cfg_wr) begin
         op = ewa_pkg::OP_CLR_INIT;
      end else begin
         case (state_ff)
            ewa_pkg::ST_IDLE:  op = start ? ewa_pkg::OP_LOAD : ewa_pkg::OP_NONE;
            ewa_pkg::ST_CLEAR: op = ewa_pkg::OP_CLR_STEP;
            ewa_pkg::ST_CHILD: op = ewa_pkg::OP_PICK;
            ewa_pkg::ST_ITEM:  op = ewa_pkg::OP_PLACE;
            ewa_pkg::ST_FINAL: op = ewa_pkg::OP_FINISH;
            default:           op = ewa_pkg::OP_NONE;
         endcase
      end
   end

   assign busy = (state_ff != ewa_pkg::ST_IDLE);

endmodule

@@ rtl/core/ewa_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewa_dpath
// Heap memory, cached root, sinking entry and result registers. Entries are
// packed as {free time, worker id}, so one unsigned compare orders them.
// ----------------------------------------------------------------------------
module ewa_dpath #(
   parameter int MAX_WORKERS = ewa_pkg::MAX_WORKERS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ewa_pkg::op_type                   op,
   input  logic [$clog2(MAX_WORKERS+1)-1:0]  workers,
   input  logic [ewa_pkg::DUR_W-1:0]         job_duration,
   output ewa_pkg::status_type               status,
   output logic                              rsp_strobe,
   output logic [ewa_pkg::IDX_W-1:0]         rsp_worker_index,
   output logic [ewa_pkg::TIME_W-1:0]        rsp_start_time
);

   localparam int AW  = $clog2(MAX_WORKERS);
   localparam int CW  = $clog2(MAX_WORKERS + 1);
   localparam int CIW = AW + 2;
   localparam int TW  = ewa_pkg::TIME_W;
   localparam int EW  = TW + AW;
   localparam int IW  = ewa_pkg::IDX_W;

   logic [EW-1:0]   heap_mem [MAX_WORKERS];

   logic [AW-1:0]   clr_idx_ff;
   logic [AW-1:0]   pos_ff;
   logic [CIW-1:0]  kid_l_ff;
   logic [EW-1:0]   rd_l_ff;
   logic [EW-1:0]   rd_r_ff;
   logic [EW-1:0]   best_ent_ff;
   logic [AW-1:0]   best_idx_ff;
   logic [EW-1:0]   item_ff;
   logic [EW-1:0]   root_ff;
   logic            strobe_ff;
   logic [IW-1:0]   rsp_idx_ff;
   logic [TW-1:0]   rsp_time_ff;

   logic [AW-1:0]   base;
   logic [CIW-1:0]  kid_l;
   logic [CIW-1:0]  kid_r;
   logic [CIW-1:0]  kid_r_q;
   logic            pick_r;
   logic [TW:0]     sum;
   logic [TW-1:0]   new_time;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [EW-1:0]   mem_wdata;

   // Children of the root on a job, of the chosen child after a swap
   assign base  = (op == ewa_pkg::OP_LOAD) ? '0 : best_idx_ff;
   assign kid_l = (CIW'(base) << 1) + CIW'(1);
   assign kid_r = kid_l + CIW'(1);

   // Smaller child of the pair just read; right child only if in the heap
   assign kid_r_q = kid_l_ff + CIW'(1);
   assign pick_r  = (kid_r_q < CIW'(workers)) && (rd_r_ff < rd_l_ff);

   // Saturating free-time update of the root
   assign sum      = {1'b0, root_ff[EW-1:AW]} + (TW + 1)'(job_duration);
   assign new_time = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

   assign status.clr_last  = (CW'(clr_idx_ff) == (workers - CW'(1)));
   assign status.has_child = (kid_l < CIW'(workers));
   assign status.swap      = (best_ent_ff < item_ff);

   // Select the memory write
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = item_ff;
      case (op)
         ewa_pkg::OP_CLR_STEP: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = {{TW{1'b0}}, clr_idx_ff};
         end
         ewa_pkg::OP_PLACE: begin
            mem_we    = 1'b1;
            mem_wdata = status.swap ? best_ent_ff : item_ff;
         end
         ewa_pkg::OP_FINISH: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Heap memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rd_l_ff <= heap_mem[kid_l[AW-1:0]];
      rd_r_ff <= heap_mem[kid_r[AW-1:0]];
   end

   // Mirror the root entry
   always_ff @(posedge clock) begin
      if (mem_we && (mem_waddr == '0)) begin
         root_ff <= mem_wdata;
      end
   end

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (op == ewa_pkg::OP_CLR_INIT) begin
         clr_idx_ff <= '0;
      end else if (op == ewa_pkg::OP_CLR_STEP) begin
         clr_idx_ff <= clr_idx_ff + AW'(1);
      end
   end

   // Sift-down registers
   always_ff @(posedge clock) begin
      case (op)
         ewa_pkg::OP_LOAD: begin
            item_ff     <= {new_time, root_ff[AW-1:0]};
            pos_ff      <= '0;
            kid_l_ff    <= kid_l;
            rsp_idx_ff  <= IW'(root_ff[AW-1:0]);
            rsp_time_ff <= root_ff[EW-1:AW];
         end
         ewa_pkg::OP_PICK: begin
            best_ent_ff <= pick_r ? rd_r_ff : rd_l_ff;
            best_idx_ff <= pick_r ? kid_r_q[AW-1:0] : kid_l_ff[AW-1:0];
         end
         ewa_pkg::OP_PLACE: begin
            if (status.swap) begin
               pos_ff   <= best_idx_ff;
               kid_l_ff <= kid_l;
            end
         end
         default: begin
            pos_ff <= pos_ff;
         end
      endcase
   end

   // Result strobe for one cycle per job
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (op == ewa_pkg::OP_LOAD);
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_worker_index = rsp_idx_ff;
   assign rsp_start_time   = rsp_time_ff;

endmodule

@@ rtl/core/earliest_free_worker_assigner.sv @@
`timescale 1ns / 1ps
// The result strobes in the cycle after start is taken.
// busy stays high per job while the sift-down runs; no new job is taken until it
// falls. Each heap level takes one child-pair read and compare, then a place.
// Reset: a clearing pass loads each entry i below workers_in_use with worker i at
// time 0; every write to workers_in_use repeats it. busy is high during the pass.
// The receiver cannot stall; rsp_strobe is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
// earliest_free_worker_assigner
// Assigns each job to the worker that becomes free earliest, using a binary
// min-heap of (free time, worker id) held in on-chip memory.
// ----------------------------------------------------------------------------
module earliest_free_worker_assigner #(
   parameter int MAX_WORKERS = ewa_pkg::MAX_WORKERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ewa_pkg::DUR_W-1:0]     req_job_duration,
   output logic                          rsp_strobe,
   output logic [ewa_pkg::IDX_W-1:0]     rsp_worker_index,
   output logic [ewa_pkg::TIME_W-1:0]    rsp_start_time,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ewa_pkg::ADDR_W-1:0]    paddr,
   input  logic [ewa_pkg::DATA_W-1:0]    pwdata,
   output logic [ewa_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   localparam int CW = $clog2(MAX_WORKERS + 1);

   logic                 cfg_wr;
   logic [CW-1:0]        workers;
   ewa_pkg::op_type      op;
   ewa_pkg::status_type  status;

   ewa_csr #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg_wr  (cfg_wr),
      .workers (workers)
   );

   ewa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cfg_wr (cfg_wr),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   ewa_dpath #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .workers          (workers),
      .job_duration     (req_job_duration),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_worker_index (rsp_worker_index),
      .rsp_start_time   (rsp_start_time)
   );

endmodule
